[rtl/lcrs_pkg.sv]
// lcrs_pkg: shared types, constants and helpers for the lane centre row-scan unit
// no dependencies; used by lcrs_datapath, lcrs_ctrl and lane_center_from_row_scan_unit
`default_nettype none

package lcrs_pkg;

  // default bounds of the scanned raster
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // register and field widths
  localparam int RW_W   = 11;  // row_width
  localparam int OW_W   = 12;  // orig_width
  localparam int OH_W   = 12;  // orig_height
  localparam int CFG_W  = 12;  // config write data
  localparam int IDX_W  = 2;   // config register index
  localparam int SUM_W  = 20;  // coordinate sums
  localparam int CNT_W  = 11;  // point counts
  localparam int OUT_W  = 11;  // center_x / center_y
  localparam int SAT_W  = 21;  // result before clamping
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam int OUT_MAX = 2047;

  localparam logic [RW_W-1:0] ROW_WIDTH_RST   = RW_W'(320);
  localparam logic [OW_W-1:0] ORIG_WIDTH_RST  = OW_W'(320);
  localparam logic [OH_W-1:0] ORIG_HEIGHT_RST = OH_W'(240);

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_WIDTH   = 2'd0,
    REG_ORIG_WIDTH  = 2'd1,
    REG_ORIG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_PREP,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  // which averaged coordinate a division produces
  typedef enum logic [1:0] {
    JOB_LX = 2'd0,
    JOB_LY = 2'd1,
    JOB_RX = 2'd2,
    JOB_RY = 2'd3
  } job_t;

  typedef struct packed {
    logic lane_pixel;
    logic left_pixel;
    logic right_pixel;
    logic row_end;
    logic frame_end;
    logic has_left;
    logic has_right;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] center_x;
    logic [OUT_W-1:0] center_y;
    logic             center_valid;
  } center_t;

  typedef struct packed {
    logic [IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] reg_data;
  } cfg_wr_t;

  typedef struct packed {
    logic pixel_take;
    logic div_load;
    logic div_store;
    job_t job;
    logic result_load;
    logic result_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic flag_left;
    logic flag_right;
    logic cnt_left_zero;
    logic cnt_right_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [SAT_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > SAT_W'(OUT_MAX)) r = OUT_W'(OUT_MAX);
    else                     r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/lcrs_chan.sv]
// lcrs_chan: valid/ready channel carrying one item of a given payload type
// no dependencies; payload types come from lcrs_pkg at instantiation
`default_nettype none

interface lcrs_chan #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/lcrs_datapath.sv]
// lcrs_datapath: config registers, row scan, frame accumulators, shared divider
// and result register; depends on lcrs_pkg
`default_nettype none

module lcrs_datapath #(
  parameter int MAX_WIDTH  = lcrs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lcrs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lcrs_pkg::pixel_t    pix,
  input  logic                cfg_we,
  input  lcrs_pkg::cfg_wr_t   cfg_wr,
  input  lcrs_pkg::dp_cmd_t   cmd,
  output lcrs_pkg::dp_status_t status,
  input  logic                res_ready,
  output logic                res_valid,
  output lcrs_pkg::center_t   res_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W = (COL_W > lcrs_pkg::RW_W) ? COL_W : lcrs_pkg::RW_W;
  localparam int SUM_W = lcrs_pkg::SUM_W;
  localparam int CNT_W = lcrs_pkg::CNT_W;
  localparam int SAT_W = lcrs_pkg::SAT_W;

  // configuration
  logic [lcrs_pkg::RW_W-1:0] row_width;
  logic [lcrs_pkg::OW_W-1:0] orig_width;
  logic [lcrs_pkg::OH_W-1:0] orig_height;

  // scan state
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] row_left_col, row_right_col;
  logic             row_left_hit, row_right_hit;
  logic [SUM_W-1:0] sum_left_x, sum_left_y, sum_right_x, sum_right_y;
  logic [CNT_W-1:0] count_left, count_right;
  logic             flag_left, flag_right;

  // divider
  logic [SUM_W-1:0]           div_quo;
  logic [CNT_W-1:0]           div_rem;
  logic [CNT_W-1:0]           div_den;
  logic [lcrs_pkg::DCNT_W-1:0] div_count;
  logic [SUM_W-1:0]           quot [4];

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= lcrs_pkg::ROW_WIDTH_RST;
      orig_width  <= lcrs_pkg::ORIG_WIDTH_RST;
      orig_height <= lcrs_pkg::ORIG_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_wr.reg_index)
        lcrs_pkg::REG_ROW_WIDTH:   row_width   <= cfg_wr.reg_data[lcrs_pkg::RW_W-1:0];
        lcrs_pkg::REG_ORIG_WIDTH:  orig_width  <= cfg_wr.reg_data[lcrs_pkg::OW_W-1:0];
        lcrs_pkg::REG_ORIG_HEIGHT: orig_height <= cfg_wr.reg_data[lcrs_pkg::OH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- row scan ----------------
  logic [CMP_W-1:0] col_x, width_x, centre_x;
  logic             in_row, both, left_only, right_only, close;
  logic             lh_next, rh_next;
  logic [COL_W-1:0] lc_next, rc_next;
  logic             row_live;

  always_comb begin
    col_x      = CMP_W'(column);
    width_x    = CMP_W'(row_width);
    centre_x   = CMP_W'(row_width >> 1);
    in_row     = col_x < width_x;
    both       = pix.has_left & pix.has_right;
    left_only  = pix.has_left & ~pix.has_right;
    right_only = ~pix.has_left & pix.has_right;
    close      = pix.row_end | pix.frame_end;
    row_live   = row < ROW_W'(MAX_HEIGHT);

    lh_next = row_left_hit;
    lc_next = row_left_col;
    rh_next = row_right_hit;
    rc_next = row_right_col;
    if (in_row) begin
      if (both) begin
        if (pix.lane_pixel && col_x <= centre_x) begin
          lh_next = 1'b1;
          lc_next = column;
        end
        if (pix.lane_pixel && col_x >= centre_x && !row_right_hit) begin
          rh_next = 1'b1;
          rc_next = column;
        end
      end else if (left_only) begin
        if (pix.left_pixel) begin
          lh_next = 1'b1;
          lc_next = column;
        end
      end else if (right_only) begin
        if (pix.right_pixel && !row_right_hit) begin
          rh_next = 1'b1;
          rc_next = column;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.result_load) begin
      column        <= '0;
      row           <= '0;
      row_left_col  <= '0;
      row_right_col <= '0;
      row_left_hit  <= 1'b0;
      row_right_hit <= 1'b0;
      sum_left_x    <= '0;
      sum_left_y    <= '0;
      sum_right_x   <= '0;
      sum_right_y   <= '0;
      count_left    <= '0;
      count_right   <= '0;
    end else if (cmd.pixel_take) begin
      if (close) begin
        if (row_live) begin
          if (lh_next) begin
            sum_left_x <= sum_left_x + SUM_W'(lc_next);
            sum_left_y <= sum_left_y + SUM_W'(row);
            count_left <= count_left + CNT_W'(1);
          end
          if (rh_next) begin
            sum_right_x <= sum_right_x + SUM_W'(rc_next);
            sum_right_y <= sum_right_y + SUM_W'(row);
            count_right <= count_right + CNT_W'(1);
          end
          row <= row + ROW_W'(1);
        end
        column        <= '0;
        row_left_hit  <= 1'b0;
        row_right_hit <= 1'b0;
        row_left_col  <= '0;
        row_right_col <= '0;
      end else begin
        // column wraps at the raster bound
        if (column == COL_W'(MAX_WIDTH - 1)) column <= '0;
        else                                 column <= column + COL_W'(1);
        row_left_hit  <= lh_next;
        row_right_hit <= rh_next;
        row_left_col  <= lc_next;
        row_right_col <= rc_next;
      end
    end
  end

  // lane flags of the last pixel pick the frame's result form
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_left  <= 1'b0;
      flag_right <= 1'b0;
    end else if (cmd.pixel_take && pix.frame_end) begin
      flag_left  <= pix.has_left;
      flag_right <= pix.has_right;
    end
  end

  // ---------------- restoring divider, one quotient bit per cycle ----------------
  logic [CNT_W:0]   div_shift, div_diff;
  logic             div_ge;
  logic [SUM_W-1:0] load_num;
  logic [CNT_W-1:0] load_den;

  always_comb begin
    div_shift = {div_rem, div_quo[SUM_W-1]};
    div_ge    = div_shift >= {1'b0, div_den};
    div_diff  = div_shift - {1'b0, div_den};
    unique case (cmd.job)
      lcrs_pkg::JOB_LX: begin load_num = sum_left_x;  load_den = count_left;  end
      lcrs_pkg::JOB_LY: begin load_num = sum_left_y;  load_den = count_left;  end
      lcrs_pkg::JOB_RX: begin load_num = sum_right_x; load_den = count_right; end
      lcrs_pkg::JOB_RY: begin load_num = sum_right_y; load_den = count_right; end
      default:          begin load_num = sum_left_x;  load_den = count_left;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (cmd.div_load) begin
      div_count <= lcrs_pkg::DCNT_W'(SUM_W);
    end else if (div_count != '0) begin
      div_count <= div_count - lcrs_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_quo <= load_num;
      div_rem <= '0;
      div_den <= load_den;
    end else if (div_count != '0) begin
      div_quo <= {div_quo[SUM_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.job)
        lcrs_pkg::JOB_LX: quot[0] <= div_quo;
        lcrs_pkg::JOB_LY: quot[1] <= div_quo;
        lcrs_pkg::JOB_RX: quot[2] <= div_quo;
        lcrs_pkg::JOB_RY: quot[3] <= div_quo;
        default: ;
      endcase
    end
  end

  // ---------------- result ----------------
  logic [SAT_W-1:0] half_h, x_raw, y_raw;

  always_comb begin
    half_h = SAT_W'(orig_height >> 1);
    if (flag_left && flag_right) begin
      x_raw = (SAT_W'(quot[0]) + SAT_W'(quot[2])) >> 1;
      y_raw = ((SAT_W'(quot[1]) + SAT_W'(quot[3])) >> 1) + half_h;
    end else if (flag_left) begin
      x_raw = SAT_W'(quot[0]);
      y_raw = SAT_W'(quot[1]) + half_h;
    end else if (flag_right) begin
      x_raw = SAT_W'(quot[2]);
      y_raw = SAT_W'(quot[3]) + half_h;
    end else begin
      x_raw = SAT_W'(orig_width >> 1);
      y_raw = SAT_W'(row >> 1) + half_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.result_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_data.center_valid <= cmd.result_ok;
      res_data.center_x     <= cmd.result_ok ? lcrs_pkg::sat_out(x_raw) : '0;
      res_data.center_y     <= cmd.result_ok ? lcrs_pkg::sat_out(y_raw) : '0;
    end
  end

  always_comb begin
    status.frame_end      = pix.frame_end;
    status.flag_left      = flag_left;
    status.flag_right     = flag_right;
    status.cnt_left_zero  = count_left == '0;
    status.cnt_right_zero = count_right == '0;
    status.div_done       = div_count == '0;
    status.out_free       = ~res_valid | res_ready;
  end

endmodule

`default_nettype wire

[rtl/lcrs_ctrl.sv]
// lcrs_ctrl: sequencer for pixel intake, frame-end divisions and result hand-off
// depends on lcrs_pkg; drives lcrs_datapath through dp_cmd_t
`default_nettype none

module lcrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  lcrs_pkg::dp_status_t status,
  output lcrs_pkg::dp_cmd_t    cmd
);

  lcrs_pkg::state_t state, state_next;
  lcrs_pkg::job_t   job, job_next;

  logic need_div, result_ok, last_job;

  always_comb begin
    // a needed empty point set makes the frame invalid and skips the divides
    need_div = (status.flag_left & status.flag_right &
                ~status.cnt_left_zero & ~status.cnt_right_zero) |
               (status.flag_left & ~status.flag_right & ~status.cnt_left_zero) |
               (~status.flag_left & status.flag_right & ~status.cnt_right_zero);
    result_ok = need_div | (~status.flag_left & ~status.flag_right);
    last_job  = (job == lcrs_pkg::JOB_RY) ||
                (job == lcrs_pkg::JOB_LY && !status.flag_right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcrs_pkg::ST_SCAN;
      job   <= lcrs_pkg::JOB_LX;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    job_next   = job;
    unique case (state)
      lcrs_pkg::ST_SCAN: begin
        if (pix_valid && status.frame_end) state_next = lcrs_pkg::ST_PREP;
      end
      lcrs_pkg::ST_PREP: begin
        if (need_div) begin
          state_next = lcrs_pkg::ST_DIV_LOAD;
          job_next   = status.flag_left ? lcrs_pkg::JOB_LX : lcrs_pkg::JOB_RX;
        end else begin
          state_next = lcrs_pkg::ST_FINISH;
        end
      end
      lcrs_pkg::ST_DIV_LOAD: begin
        state_next = lcrs_pkg::ST_DIV_RUN;
      end
      lcrs_pkg::ST_DIV_RUN: begin
        if (status.div_done) begin
          if (last_job) begin
            state_next = lcrs_pkg::ST_FINISH;
          end else begin
            state_next = lcrs_pkg::ST_DIV_LOAD;
            unique case (job)
              lcrs_pkg::JOB_LX: job_next = lcrs_pkg::JOB_LY;
              lcrs_pkg::JOB_LY: job_next = lcrs_pkg::JOB_RX;
              lcrs_pkg::JOB_RX: job_next = lcrs_pkg::JOB_RY;
              default:          job_next = lcrs_pkg::JOB_RY;
            endcase
          end
        end
      end
      lcrs_pkg::ST_FINISH: begin
        if (status.out_free) state_next = lcrs_pkg::ST_SCAN;
      end
      default: state_next = lcrs_pkg::ST_SCAN;
    endcase
  end

  // outputs
  always_comb begin
    pix_ready       = 1'b0;
    cmd.pixel_take  = 1'b0;
    cmd.div_load    = 1'b0;
    cmd.div_store   = 1'b0;
    cmd.job         = job;
    cmd.result_load = 1'b0;
    cmd.result_ok   = result_ok;
    unique case (state)
      lcrs_pkg::ST_SCAN: begin
        pix_ready      = 1'b1;
        cmd.pixel_take = pix_valid;
      end
      lcrs_pkg::ST_PREP: ;
      lcrs_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
      end
      lcrs_pkg::ST_DIV_RUN: begin
        cmd.div_store = status.div_done;
      end
      lcrs_pkg::ST_FINISH: begin
        cmd.result_load = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/lane_center_from_row_scan_unit.sv]
// Lane center from a raster scan of binary lane planes. Pixels are taken one per
// clock in raster order while a frame is being scanned; each row contributes at
// most one left and one right point to running sums. On the frame's last pixel
// the unit stops taking pixels and averages the sums with one shared restoring
// divider that yields one quotient bit per cycle. The number of averages after
// a frame_end pixel is 4 with both lanes, 2 with one lane and 0 with no lane
// or an empty point set. The result sits in an output register, so the next
// frame may start while it waits to be taken; a frame that ends while the
// previous result is still held stalls further until that result is taken.
// Config writes are always accepted and are meant for idle periods. Depends on
// lcrs_pkg, lcrs_chan, lcrs_ctrl and lcrs_datapath.
`default_nettype none

module lane_center_from_row_scan_unit #(
  parameter int MAX_WIDTH  = lcrs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lcrs_pkg::MAX_HEIGHT_DEF
) (
  input logic      clk,
  input logic      rst,
  lcrs_chan.sink   pixel,
  lcrs_chan.sink   cfg,
  lcrs_chan.source center
);

  lcrs_pkg::dp_cmd_t    cmd;
  lcrs_pkg::dp_status_t status;
  lcrs_pkg::pixel_t     pix;
  lcrs_pkg::cfg_wr_t    cfg_wr;
  lcrs_pkg::center_t    res_data;
  logic                 pix_ready;
  logic                 res_valid;

  assign pix         = pixel.data;
  assign cfg_wr      = cfg.data;
  assign pixel.ready = pix_ready;
  assign cfg.ready   = 1'b1;
  assign center.valid = res_valid;
  assign center.data  = res_data;

  lcrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pixel.valid),
    .pix_ready (pix_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcrs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .cfg_we    (cfg.valid),
    .cfg_wr    (cfg_wr),
    .cmd       (cmd),
    .status    (status),
    .res_ready (center.ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
